FILE: rtl/core/eitm_pkg.sv
`default_nettype none
package eitm_pkg;

  // Depth of the interval store and width of the tick values.
  localparam int MAX_SAMPLES = 23;
  localparam int TIME_WIDTH  = 32;

  // Widths derived from the store depth.
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = TIME_WIDTH;
  localparam int SC_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [TIME_WIDTH-1:0] low_limit;
    logic [TIME_WIDTH-1:0] high_limit;
    logic [SC_W-1:0]       sample_count;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic calc;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_done;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/eitm_ctrl.sv
`default_nettype none
module eitm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire eitm_pkg::status_t status_i,
  output eitm_pkg::cmd_t        cmd_o
);
  import eitm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_PICK
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   accept;

  assign in_stall_o = stall_q;
  assign accept     = in_valid_i && !stall_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    stall_d = stall_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = accept;
        if (accept && status_i.run_done) begin
          state_d = S_SCAN;
          stall_d = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_PICK;
      end
      S_PICK: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
          stall_d        = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  // State and registered stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  // Input is taken only in the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == S_IDLE)
    else $error("input open outside the idle state");

  // A completing transfer always starts the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.run_done) |=> state_q == S_SCAN && in_stall_o)
    else $error("completed run did not start the scan");

  // The calculation step is followed by the pick in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC |=> state_q == S_PICK)
    else $error("calculation step not followed by the pick");

endmodule
`default_nettype wire

FILE: rtl/core/eitm_datapath.sv
`default_nettype none
module eitm_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire eitm_pkg::cfg_t                  cfg_i,
  input  wire eitm_pkg::cmd_t                  cmd_i,
  output eitm_pkg::status_t                    status_o,
  input  wire logic [eitm_pkg::TIME_WIDTH-1:0] event_time_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [eitm_pkg::TIME_WIDTH-1:0]      median_ticks_o,
  output logic                                 found_o,
  output logic [eitm_pkg::CNT_W-1:0]           kept_count_o
);
  import eitm_pkg::*;

  // Run state.
  logic [TIME_WIDTH-1:0] prev_q;
  logic                  have_start_q;
  logic [CNT_W-1:0]      count_q, count_d;

  // Sorted interval store: entries below count_q are valid, in ascending order.
  logic [TIME_WIDTH-1:0] store_q [MAX_SAMPLES];
  logic [TIME_WIDTH-1:0] store_d [MAX_SAMPLES];

  // Scan and selection registers.
  logic [IDX_W-1:0]      idx_q;
  logic [CNT_W-1:0]      low_cnt_q, high_cnt_q, kept_q;

  // Output register.
  logic                  out_valid_q;
  logic [TIME_WIDTH-1:0] median_q;
  logic                  found_q;
  logic [CNT_W-1:0]      kept_out_q;

  logic [TIME_WIDTH-1:0] interval;
  logic [MAX_SAMPLES-1:0] gt;
  logic [CNT_W-1:0]      target;
  logic                  insert;
  logic [TIME_WIDTH-1:0] rd_data;
  logic [CNT_W:0]        rej_sum;
  logic [CNT_W-1:0]      kept_calc;
  logic [CNT_W-1:0]      pick_idx;

  assign interval = event_time_i - prev_q;
  assign insert   = cmd_i.accept && have_start_q;
  assign count_d  = count_q + CNT_W'(1);
  assign rd_data  = store_q[idx_q];

  // Effective run length: zero or out of range selects the full store.
  always_comb begin
    if (cfg_i.sample_count == '0 || cfg_i.sample_count > SC_W'(MAX_SAMPLES)) begin
      target = CNT_W'(MAX_SAMPLES);
    end else begin
      target = cfg_i.sample_count[CNT_W-1:0];
    end
  end

  // Insertion: every valid entry above the new interval moves up by one place.
  always_comb begin
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      gt[k] = (CNT_W'(k) < count_q) && (store_q[k] > interval);
    end
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
        store_d[k] = store_q[(k > 0) ? k - 1 : 0];
      end else if (gt[k] || CNT_W'(k) == count_q) begin
        store_d[k] = interval;
      end else begin
        store_d[k] = store_q[k];
      end
    end
  end

  // Kept count and index of the upper median among the survivors.
  always_comb begin
    rej_sum = {1'b0, low_cnt_q} + {1'b0, high_cnt_q};
    if (rej_sum >= {1'b0, count_q}) begin
      kept_calc = '0;
    end else begin
      kept_calc = count_q - rej_sum[CNT_W-1:0];
    end
    pick_idx = low_cnt_q + (kept_calc >> 1);
  end

  always_comb begin
    status_o.run_done  = have_start_q && (count_d >= target);
    status_o.scan_last = (CNT_W'(idx_q) == count_q - CNT_W'(1));
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Control registers of the run and the output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_start_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        have_start_q <= !have_start_q ? 1'b1 : !status_o.run_done;
      end
      if (insert) begin
        count_q <= count_d;
      end else if (cmd_i.load_out) begin
        count_q <= '0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Store, scan counters and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      prev_q <= event_time_i;
    end
    if (insert) begin
      store_q <= store_d;
    end
    if (insert) begin
      idx_q      <= '0;
      low_cnt_q  <= '0;
      high_cnt_q <= '0;
    end else if (cmd_i.scan_step) begin
      idx_q      <= idx_q + IDX_W'(1);
      low_cnt_q  <= low_cnt_q + CNT_W'(rd_data <= cfg_i.low_limit);
      high_cnt_q <= high_cnt_q + CNT_W'(rd_data >= cfg_i.high_limit);
    end else if (cmd_i.calc) begin
      idx_q  <= pick_idx[IDX_W-1:0];
      kept_q <= kept_calc;
    end
    if (cmd_i.load_out) begin
      median_q   <= (kept_q != '0) ? rd_data : '0;
      found_q    <= (kept_q != '0);
      kept_out_q <= kept_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_ticks_o = median_q;
  assign found_o        = found_q;
  assign kept_count_o   = kept_out_q;

  // The store never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SAMPLES))
    else $error("stored interval count beyond the store depth");

  // A result without survivors carries a zero median.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (median_q == '0 && kept_out_q == '0))
    else $error("empty result with non-zero payload");

  // A result is never loaded over one still waiting for its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

  // After a completed run the next transfer only sets the start time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> (!have_start_q && count_q == '0))
    else $error("run not re-armed after its result");

endmodule
`default_nettype wire

FILE: rtl/core/event_interval_trimmed_median.sv
// Sequence: an event that completes a run starts a scan of the stored intervals, of which
// there are at most 23, then a calculation step and a pick that loads the output register.
// Throughput: one event per cycle within a run; the completing event closes the input
// while the sorted store is scanned one entry per cycle and the pick is calculated, and
// for longer while the receiver still holds off the previous result.
// Reset: run state and handshakes clear at once, limits return to their defaults.
`default_nettype none
module event_interval_trimmed_median (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [eitm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [eitm_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [eitm_pkg::TIME_WIDTH-1:0] event_time_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [eitm_pkg::TIME_WIDTH-1:0]      median_ticks_o,
  output logic                                 found_o,
  output logic [eitm_pkg::CNT_W-1:0]           kept_count_o
);
  import eitm_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit    <= '0;
      cfg_q.high_limit   <= '1;
      cfg_q.sample_count <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_LIMIT:    cfg_q.low_limit    <= cfg_data_i[TIME_WIDTH-1:0];
        CFG_HIGH_LIMIT:   cfg_q.high_limit   <= cfg_data_i[TIME_WIDTH-1:0];
        CFG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data_i[SC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  eitm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Interval store, scan and result register.
  eitm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .event_time_i   (event_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .median_ticks_o (median_ticks_o),
    .found_o        (found_o),
    .kept_count_o   (kept_count_o)
  );

endmodule
`default_nettype wire
